@@ rtl/core/clld_pkg.sv @@
// Shared types, constants and helper functions of the content-length deframer.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package clld_pkg;

    localparam int LINE_CAP_DEF    = 8192;
    localparam int LENGTH_BITS_DEF = 32;
    localparam int PREFIX_LEN      = 15;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef enum logic [2:0] {
        K_BYTE    = 3'd0,
        K_EMPTY   = 3'd1,
        K_MISSING = 3'd2,
        K_TRUNC   = 3'd3,
        K_EOI     = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        PH_HEADER = 2'b01,
        PH_BODY   = 2'b10
    } t_phase;

    typedef enum logic [3:0] {
        NS_BLANKS = 4'b0001,
        NS_SIGN   = 4'b0010,
        NS_DIGITS = 4'b0100,
        NS_DONE   = 4'b1000
    } t_num_stage;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] body_byte;
        logic       last;
    } t_result;

    // Lower-case header name, one character per column.
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h63; // c
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h6C; // l
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            4'd14:   ch = 8'h3A; // :
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/content_length_deframer.sv @@
// Top level of the content-length deframer: parser state plus result register.
// Depends on clld_pkg, clld_parser and clld_out_reg.
//
// The input channel (i_valid / o_ready) carries one transaction per raw stream byte,
// with i_end_of_stream marking the end of input (its data byte is ignored). Header
// lines end in LF and CR bytes are dropped. A "content-length:" header in any letter
// case sets the body length, parsed like a decimal strtol that saturates at the top
// of the LENGTH_BITS range; the last such header wins. A blank line ends the headers.
// The output channel (o_valid / i_ready) carries at most one result transaction per
// input transaction: a body byte (kind 0, last set on the final one), an empty
// message, a missing length, a truncated body, or the end of input.
// A result is presented in the cycle after its input byte is accepted. Input is taken at
// one byte per cycle while the result register has room, the parser updating its state
// on each accepted byte and feeding the one-entry result register.
// When the receiver stalls, the pending result holds and o_ready stays high only if
// that result is taken in the same cycle; bytes that make no result are still taken
// at full rate while the register is free. A synchronous active-low reset returns
// the parser to the header phase with no length and empties the result register.
`default_nettype none

module content_length_deframer #(
    parameter int LINE_CAP    = clld_pkg::LINE_CAP_DEF,
    parameter int LENGTH_BITS = clld_pkg::LENGTH_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_end_of_stream,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [2:0]      o_kind,
    output logic [7:0]      o_body_byte,
    output logic            o_last
);

    logic              accept;
    clld_pkg::t_result result;

    // An input transaction is taken whenever the result register has room.
    assign accept = i_valid && o_ready;

    clld_parser #(
        .LINE_CAP    (LINE_CAP),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_result        (result)
    );

    clld_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_result    (result),
        .i_ready     (i_ready),
        .o_can_load  (o_ready),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_body_byte (o_body_byte),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

@@ rtl/core/clld_parser.sv @@
// Framing state and its next-state logic: header line scanning, length parsing, body count.
// Depends on clld_pkg.
`default_nettype none

module clld_parser #(
    parameter int LINE_CAP    = clld_pkg::LINE_CAP_DEF,
    parameter int LENGTH_BITS = clld_pkg::LENGTH_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_end_of_stream,
    output clld_pkg::t_result     o_result
);

    localparam int CW = $clog2(LINE_CAP);
    localparam int LB = LENGTH_BITS;

    clld_pkg::t_phase     r_phase, n_phase;
    logic [CW-1:0]        r_column, n_column;
    logic                 r_prefix_ok, n_prefix_ok;
    clld_pkg::t_num_stage r_stage, n_stage;
    logic                 r_negative, n_negative;
    logic [LB-1:0]        r_value, n_value;
    logic                 r_known, n_known;
    logic [LB-1:0]        r_remain, n_remain;
    logic                 r_started, n_started;

    always_comb begin
        logic             new_line;
        logic             new_message;
        logic [7:0]       lc;
        logic [LB+3:0]    wide;
        logic [LB-1:0]    remain_dec;
        logic             is_blank;
        logic             is_digit;
        logic             in_digits;

        n_phase     = r_phase;
        n_column    = r_column;
        n_prefix_ok = r_prefix_ok;
        n_stage     = r_stage;
        n_negative  = r_negative;
        n_value     = r_value;
        n_known     = r_known;
        n_remain    = r_remain;
        n_started   = r_started;
        new_line    = 1'b0;
        new_message = 1'b0;

        o_result           = '0;
        o_result.kind      = clld_pkg::K_BYTE;

        lc = ((i_data_byte >= clld_pkg::CH_UP_A) && (i_data_byte <= clld_pkg::CH_UP_Z))
           ? (i_data_byte | clld_pkg::CASE_BIT) : i_data_byte;
        is_blank = (i_data_byte == clld_pkg::CH_SPACE) || (i_data_byte == clld_pkg::CH_TAB)
                || (i_data_byte == clld_pkg::CH_VT) || (i_data_byte == clld_pkg::CH_FF);
        is_digit = (i_data_byte >= clld_pkg::CH_ZERO) && (i_data_byte <= clld_pkg::CH_NINE);
        // value * 10 + digit, never above 10 * max + 9, so four extra bits suffice.
        wide = ({4'b0, r_value} << 3) + ({4'b0, r_value} << 1)
             + {{LB{1'b0}}, i_data_byte[3:0]};
        remain_dec = (r_remain != '0) ? (r_remain - 1'b1) : r_remain;
        in_digits = 1'b0;

        if (i_accept) begin
            if (i_end_of_stream) begin
                o_result.valid = 1'b1;
                o_result.kind  = clld_pkg::K_EOI;
                if (r_phase == clld_pkg::PH_BODY) begin
                    o_result.kind = clld_pkg::K_TRUNC;
                end else if (r_started && (r_column == '0)) begin
                    // A line that only held CR bytes ends the headers.
                    if (!r_known) begin
                        o_result.kind = clld_pkg::K_MISSING;
                    end else if (r_remain == '0) begin
                        o_result.kind = clld_pkg::K_EMPTY;
                    end else begin
                        o_result.kind = clld_pkg::K_TRUNC;
                    end
                end
                new_message = 1'b1;
            end else if (r_phase == clld_pkg::PH_BODY) begin
                o_result.valid     = 1'b1;
                o_result.body_byte = i_data_byte;
                n_remain           = remain_dec;
                if (remain_dec == '0) begin
                    o_result.last = 1'b1;
                    new_message   = 1'b1;
                end
            end else begin
                n_started = 1'b1;
                if (i_data_byte == clld_pkg::CH_CR) begin
                    // Carriage returns are dropped.
                end else if (i_data_byte != clld_pkg::CH_LF) begin
                    if (r_column < CW'(LINE_CAP - 1)) begin
                        n_column = r_column + 1'b1;
                        if (r_column < CW'(clld_pkg::PREFIX_LEN)) begin
                            if (lc != clld_pkg::name_char(r_column[3:0])) begin
                                n_prefix_ok = 1'b0;
                            end
                        end else if (r_prefix_ok) begin
                            case (r_stage)
                                clld_pkg::NS_BLANKS: begin
                                    if (is_blank) begin
                                        n_stage = r_stage;
                                    end else if ((i_data_byte == clld_pkg::CH_PLUS) ||
                                                 (i_data_byte == clld_pkg::CH_MINUS)) begin
                                        n_negative = (i_data_byte == clld_pkg::CH_MINUS);
                                        n_stage    = clld_pkg::NS_SIGN;
                                    end else begin
                                        in_digits = 1'b1;
                                    end
                                end
                                clld_pkg::NS_SIGN:   in_digits = 1'b1;
                                clld_pkg::NS_DIGITS: in_digits = 1'b1;
                                clld_pkg::NS_DONE:   n_stage = r_stage;
                                default:             n_stage = r_stage;
                            endcase
                            if (in_digits) begin
                                if (is_digit) begin
                                    n_stage = clld_pkg::NS_DIGITS;
                                    n_value = (wide[LB+3:LB] != 4'b0) ? {LB{1'b1}}
                                                                      : wide[LB-1:0];
                                end else begin
                                    n_stage = clld_pkg::NS_DONE;
                                end
                            end
                        end
                    end
                end else if (r_column == '0) begin
                    if (!r_known) begin
                        o_result.valid = 1'b1;
                        o_result.kind  = clld_pkg::K_MISSING;
                        new_message    = 1'b1;
                    end else if (r_remain == '0) begin
                        o_result.valid = 1'b1;
                        o_result.kind  = clld_pkg::K_EMPTY;
                        new_message    = 1'b1;
                    end else begin
                        new_line = 1'b1;
                        n_phase  = clld_pkg::PH_BODY;
                    end
                end else begin
                    if ((r_column >= CW'(clld_pkg::PREFIX_LEN)) && r_prefix_ok) begin
                        // A negative nonzero value counts as no length; minus zero is zero.
                        if (r_negative && (r_value != '0)) begin
                            n_known  = 1'b0;
                            n_remain = '0;
                        end else begin
                            n_known  = 1'b1;
                            n_remain = r_value;
                        end
                    end
                    new_line = 1'b1;
                end
            end
        end

        if (new_message) begin
            n_phase  = clld_pkg::PH_HEADER;
            n_known  = 1'b0;
            n_remain = '0;
        end
        if (new_line || new_message) begin
            n_column    = '0;
            n_prefix_ok = 1'b1;
            n_stage     = clld_pkg::NS_BLANKS;
            n_negative  = 1'b0;
            n_value     = '0;
            n_started   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= clld_pkg::PH_HEADER;
            r_column    <= '0;
            r_prefix_ok <= 1'b1;
            r_stage     <= clld_pkg::NS_BLANKS;
            r_negative  <= 1'b0;
            r_value     <= '0;
            r_known     <= 1'b0;
            r_remain    <= '0;
            r_started   <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_column    <= n_column;
            r_prefix_ok <= n_prefix_ok;
            r_stage     <= n_stage;
            r_negative  <= n_negative;
            r_value     <= n_value;
            r_known     <= n_known;
            r_remain    <= n_remain;
            r_started   <= n_started;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/clld_out_reg.sv @@
// Result register of the deframer: holds one result until the receiver takes it.
// Depends on clld_pkg.
`default_nettype none

module clld_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire clld_pkg::t_result i_result,
    input  wire logic              i_ready,
    output logic                   o_can_load,
    output logic                   o_valid,
    output logic [2:0]             o_kind,
    output logic [7:0]             o_body_byte,
    output logic                   o_last
);

    logic                  r_valid, n_valid;
    clld_pkg::t_result     r_result;

    // Room exists when the register is empty or its content leaves this cycle.
    assign o_can_load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (o_can_load) begin
            n_valid = i_load && i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load && i_result.valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid     = r_valid;
    assign o_kind      = r_result.kind;
    assign o_body_byte = r_result.body_byte;
    assign o_last      = r_result.last;

endmodule

`default_nettype wire

@@ rtl/core/clld_checker.sv @@
// Port-level checks of the content-length deframer, bound to its top level.
// Depends on clld_pkg and content_length_deframer.
`default_nettype none

module clld_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       i_end_of_stream,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [2:0] o_kind,
    input wire logic [7:0] o_body_byte,
    input wire logic       o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_body_byte)
                                && $stable(o_last))
        else $error("output transaction changed while stalled");

    a_ctrl_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != clld_pkg::K_BYTE) |-> (o_body_byte == 8'h00) && !o_last)
        else $error("control result carries body data");

    a_eos_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_end_of_stream |=> o_valid &&
            ((o_kind == clld_pkg::K_EMPTY) || (o_kind == clld_pkg::K_MISSING) ||
             (o_kind == clld_pkg::K_TRUNC) || (o_kind == clld_pkg::K_EOI)))
        else $error("end of stream produced no end result");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty result register");

endmodule

bind content_length_deframer clld_checker u_clld_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .i_end_of_stream (i_end_of_stream),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_kind          (o_kind),
    .o_body_byte     (o_body_byte),
    .o_last          (o_last)
);

`default_nettype wire
